// File: hw/rtl/wavp_pkg.sv
`default_nettype none

package wavp_pkg;

  // Chunk tags as they appear in the stream, first byte in the top octet.
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Length of the fmt body that is decoded, and the only accepted format.
  localparam logic [31:0] FMT_BODY = 32'd16;
  localparam logic [15:0] PCM_CODE = 16'd1;
  localparam logic [15:0] PCM_BITS = 16'd16;

  // Result kinds.
  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NOT_WAVE   = 3'd0;
  localparam logic [2:0] ERR_BAD_FMT    = 3'd1;
  localparam logic [2:0] ERR_NOT_PCM    = 3'd2;
  localparam logic [2:0] ERR_NOT_16BIT  = 3'd3;
  localparam logic [2:0] ERR_MISSING    = 3'd4;
  localparam logic [2:0] ERR_SHORT_DATA = 3'd5;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_CHDR,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_DONE,
    PH_ERR
  } phase_t;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  byte_position;
    logic [31:0] chunk_length;
    logic [31:0] chunk_tag;
    logic [15:0] field_shift;
    logic [15:0] first_of_pair;
    logic        format_seen;
    logic        pad_pending;
    logic [15:0] saved_channels;
    logic [31:0] saved_rate;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:          PH_HDR,
    byte_position:  4'd0,
    chunk_length:   32'd0,
    chunk_tag:      32'd0,
    field_shift:    16'd0,
    first_of_pair:  16'd0,
    format_seen:    1'b0,
    pad_pending:    1'b0,
    saved_channels: 16'd0,
    saved_rate:     32'd0
  };

  // One result item.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [16:0] mono_sum;
    logic               end_of_data;
    logic [15:0]        channel_count;
    logic [31:0]        rate_hz;
    logic [2:0]         error_code;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/wavp_step.sv
`default_nettype none

// Next-state and result logic for one byte or end-of-file request.
module wavp_step (
  input  wire wavp_pkg::state_t  cur,
  input  wire logic              op,
  input  wire logic [7:0]        data_byte,
  output wavp_pkg::state_t       nxt,
  output logic                   res_valid,
  output wavp_pkg::result_t      res
);
  import wavp_pkg::*;

  logic [3:0]  p;
  logic [3:0]  p_inc;
  logic [1:0]  q;
  logic [31:0] tag_shifted;
  logic [31:0] len_chdr;
  logic [31:0] len_dec;
  logic [31:0] len_fmt_rest;
  logic [15:0] second_word;
  logic signed [16:0] pair_sum;

  assign p           = cur.byte_position;
  assign p_inc       = p + 4'd1;
  assign q           = p[1:0];
  assign tag_shifted = {cur.chunk_tag[23:0], data_byte};
  assign len_dec     = cur.chunk_length - 32'd1;
  assign len_fmt_rest = cur.chunk_length - FMT_BODY;
  assign second_word = {data_byte, cur.field_shift[7:0]};
  assign pair_sum    = $signed({cur.first_of_pair[15], cur.first_of_pair})
                     + $signed({second_word[15], second_word});

  // Length field of a chunk header, little-endian, cleared at the first tag byte.
  always_comb begin
    if (p == 4'd0) begin
      len_chdr = 32'd0;
    end else if (p[2]) begin
      len_chdr = cur.chunk_length | ({24'd0, data_byte} << {q, 3'b000});
    end else begin
      len_chdr = cur.chunk_length;
    end
  end

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;

    if (op) begin
      // End of file: report what was cut short, then start over.
      nxt = STATE_RESET;
      unique case (cur.phase)
        PH_HDR: begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_NOT_WAVE;
        end
        PH_CHDR, PH_SKIP: begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_MISSING;
        end
        PH_FMT: begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_BAD_FMT;
        end
        PH_DATA: begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_SHORT_DATA;
        end
        default: begin
        end
      endcase
    end else begin
      unique case (cur.phase)
        // RIFF size bytes are not part of either tag.
        PH_HDR: begin
          if (p < 4'd4 || p >= 4'd8) begin
            nxt.chunk_tag = tag_shifted;
          end
          nxt.byte_position = p_inc;
          if (p == 4'd3 && tag_shifted != TAG_RIFF) begin
            nxt.phase      = PH_ERR;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_NOT_WAVE;
          end else if (p == 4'd11) begin
            if (tag_shifted != TAG_WAVE) begin
              nxt.phase      = PH_ERR;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_NOT_WAVE;
            end else begin
              nxt.phase         = PH_CHDR;
              nxt.byte_position = 4'd0;
            end
          end
        end

        // Chunk header: four tag bytes, four length bytes, then dispatch.
        PH_CHDR: begin
          if (!p[2]) begin
            nxt.chunk_tag = tag_shifted;
          end
          nxt.chunk_length  = len_chdr;
          nxt.byte_position = p_inc;
          if (p == 4'd7) begin
            nxt.byte_position = 4'd0;
            if (cur.chunk_tag == TAG_FMT) begin
              if (len_chdr < FMT_BODY) begin
                nxt.phase      = PH_ERR;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_BAD_FMT;
              end else begin
                nxt.phase          = PH_FMT;
                nxt.first_of_pair  = 16'd0;
                nxt.field_shift    = 16'd0;
                nxt.saved_channels = 16'd0;
                nxt.saved_rate     = 32'd0;
              end
            end else if (cur.chunk_tag == TAG_DATA) begin
              if (!cur.format_seen) begin
                nxt.phase      = PH_ERR;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_MISSING;
              end else if (len_chdr == 32'd0) begin
                nxt.phase = PH_DONE;
                res_valid = 1'b1;
                res.kind  = KIND_DONE;
              end else begin
                nxt.phase = PH_DATA;
              end
            end else begin
              // Unknown chunk: skip its body and pad byte.
              nxt.pad_pending = len_chdr[0];
              nxt.phase = (len_chdr == 32'd0 && !len_chdr[0]) ? PH_CHDR : PH_SKIP;
            end
          end
        end

        // Format body: tag, channels, rate, and bits per sample at the end.
        PH_FMT: begin
          if (p < 4'd2) begin
            nxt.first_of_pair = cur.first_of_pair | ({8'd0, data_byte} << {p[0], 3'b000});
          end else if (p < 4'd4) begin
            nxt.saved_channels = cur.saved_channels
                               | ({8'd0, data_byte} << {p[0], 3'b000});
          end else if (p < 4'd8) begin
            nxt.saved_rate = cur.saved_rate | ({24'd0, data_byte} << {q, 3'b000});
          end else if (p >= 4'd14) begin
            nxt.field_shift = cur.field_shift | ({8'd0, data_byte} << {p[0], 3'b000});
          end
          nxt.byte_position = p_inc;
          if (p == 4'd15) begin
            nxt.byte_position = 4'd0;
            if (cur.first_of_pair != PCM_CODE) begin
              nxt.phase      = PH_ERR;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_NOT_PCM;
            end else if (second_word != PCM_BITS) begin
              nxt.phase      = PH_ERR;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_NOT_16BIT;
            end else begin
              nxt.format_seen   = 1'b1;
              nxt.chunk_length  = len_fmt_rest;
              nxt.pad_pending   = cur.chunk_length[0];
              nxt.phase = (len_fmt_rest == 32'd0 && !cur.chunk_length[0]) ? PH_CHDR
                                                                           : PH_SKIP;
              res_valid         = 1'b1;
              res.kind          = KIND_FORMAT;
              res.channel_count = cur.saved_channels;
              res.rate_hz       = cur.saved_rate;
            end
          end
        end

        // Skip the rest of a chunk, then its pad byte.
        PH_SKIP: begin
          if (cur.chunk_length != 32'd0) begin
            nxt.chunk_length = len_dec;
            if (len_dec == 32'd0 && !cur.pad_pending) begin
              nxt.phase         = PH_CHDR;
              nxt.byte_position = 4'd0;
            end
          end else begin
            nxt.pad_pending   = 1'b0;
            nxt.phase         = PH_CHDR;
            nxt.byte_position = 4'd0;
          end
        end

        // Sample data: two little-endian words make one mono sum.
        PH_DATA: begin
          nxt.chunk_length  = len_dec;
          nxt.byte_position = {2'b00, q + 2'd1};
          unique case (q)
            2'd0: nxt.first_of_pair = {8'd0, data_byte};
            2'd1: nxt.first_of_pair = {data_byte, cur.first_of_pair[7:0]};
            2'd2: nxt.field_shift   = {8'd0, data_byte};
            2'd3: nxt.field_shift   = second_word;
            default: begin
            end
          endcase
          if (q == 2'd3) begin
            res_valid       = 1'b1;
            res.kind        = KIND_SAMPLE;
            res.mono_sum    = pair_sum;
            res.end_of_data = (len_dec < 32'd4);
            if (len_dec == 32'd0) begin
              nxt.phase = PH_DONE;
            end
          end else if (len_dec == 32'd0) begin
            nxt.phase = PH_DONE;
            res_valid = 1'b1;
            res.kind  = KIND_DONE;
          end
        end

        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/wav_pcm16_chunk_parser.sv
// Throughput: one byte or end-of-file request per cycle while not stalled; the
// parse state is updated in one pass through the step logic between input and
// result register. A byte that gives no result moves on even while the result
// register is stalled.
// Reset (rst, synchronous, active high) empties both registers and returns the
// parser to waiting for the RIFF header.
`default_nettype none

module wav_pcm16_chunk_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               op,
  input  wire logic [7:0]         data_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              kind,
  output logic signed [16:0]      mono_sum,
  output logic                    end_of_data,
  output logic [15:0]             channel_count,
  output logic [31:0]             rate_hz,
  output logic [2:0]              error_code
);
  import wavp_pkg::*;

  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_byte;
  state_t     st;
  state_t     st_next;
  logic       res_valid;
  result_t    res;
  logic       advance;

  wavp_step u_step (
    .cur       (st),
    .op        (s1_op),
    .data_byte (s1_byte),
    .nxt       (st_next),
    .res_valid (res_valid),
    .res       (res)
  );

  // The held request moves on unless its result would overwrite a stalled one.
  assign advance  = s1_valid && (!res_valid || !out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= STATE_RESET;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
        s1_op    <= op;
        s1_byte  <= data_byte;
      end
      if (advance) begin
        st <= st_next;
      end
      if (advance && res_valid) begin
        out_valid     <= 1'b1;
        kind          <= res.kind;
        mono_sum      <= res.mono_sum;
        end_of_data   <= res.end_of_data;
        channel_count <= res.channel_count;
        rate_hz       <= res.rate_hz;
        error_code    <= res.error_code;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/wavp_checker.sv
`default_nettype none

module wavp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         kind,
  input wire logic signed [16:0] mono_sum,
  input wire logic               end_of_data,
  input wire logic [15:0]        channel_count,
  input wire logic [31:0]        rate_hz,
  input wire logic [2:0]         error_code
);
  import wavp_pkg::*;

  // A stalled result keeps its valid and its fields.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(mono_sum)
      && $stable(end_of_data) && $stable(channel_count) && $stable(rate_hz)
      && $stable(error_code))
    else $error("stalled result changed");

  // Only a sample result carries a sum or the end-of-data flag.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_SAMPLE |-> mono_sum == 17'sd0 && !end_of_data)
    else $error("sample fields set on a non-sample result");

  // Only a format result carries channels and rate.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_FORMAT |-> channel_count == 16'd0 && rate_hz == 32'd0)
    else $error("format fields set on a non-format result");

  // Error codes stay in range and appear only on error results.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_ERROR) ? (error_code <= ERR_SHORT_DATA)
                                       : (error_code == ERR_NOT_WAVE))
    else $error("bad error code");

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind wav_pcm16_chunk_parser wavp_checker u_wavp_checker (.*);

`default_nettype wire

// File: dv/tb_top.sv
module tb_top;
  import wavp_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int TOTAL_ITEMS = 1150;
  localparam int HOLD_CYCLES = 80;

  // One request to the parser: a file byte or the end-of-file marker.
  typedef struct {
    logic       eof;
    logic [7:0] b;
    bit         drain;
  } request_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = 1'b0;
  logic [7:0]         data_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         kind;
  logic signed [16:0] mono_sum;
  logic               end_of_data;
  logic [15:0]        channel_count;
  logic [31:0]        rate_hz;
  logic [2:0]         error_code;

  request_t   req_q[$];
  logic [7:0] file_q[$];
  result_t    parse_results_q[$];

  int  errors = 0;
  int  idle_cycles = 0;
  int  cycle_count = 0;
  int  samples_seen = 0;
  bit  quiet_mode = 1'b0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;
  bit  sample_took = 1'b0;
  int  send_wait = 0;
  int  rcv_wait = 0;
  int  rcv_hold = 0;

  // Predicted parser state.
  phase_t      pr_phase;
  logic [31:0] pr_pos;
  logic [31:0] pr_left;
  logic [31:0] pr_tag;
  logic [15:0] pr_word_a;
  logic [15:0] pr_word_b;
  logic        pr_have_fmt;
  logic        pr_pad;
  logic [15:0] pr_chans;
  logic [31:0] pr_rate;

  wav_pcm16_chunk_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .mono_sum      (mono_sum),
    .end_of_data   (end_of_data),
    .channel_count (channel_count),
    .rate_hz       (rate_hz),
    .error_code    (error_code)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parse predictor
  // ---------------------------------------------------------------------------

  task automatic clear_parser();
    pr_phase    = PH_HDR;
    pr_pos      = '0;
    pr_left     = '0;
    pr_tag      = '0;
    pr_word_a   = '0;
    pr_word_b   = '0;
    pr_have_fmt = 1'b0;
    pr_pad      = 1'b0;
    pr_chans    = '0;
    pr_rate     = '0;
  endtask

  task automatic add_result(logic [1:0] k, logic signed [16:0] s, logic eod,
                            logic [15:0] ch, logic [31:0] rate, logic [2:0] err);
    result_t r;
    r.kind          = k;
    r.mono_sum      = s;
    r.end_of_data   = eod;
    r.channel_count = ch;
    r.rate_hz       = rate;
    r.error_code    = err;
    parse_results_q.push_back(r);
  endtask

  task automatic report_error(logic [2:0] code);
    pr_phase = PH_ERR;
    add_result(KIND_ERROR, '0, 1'b0, '0, '0, code);
  endtask

  task automatic start_skip(logic [31:0] len, logic pad);
    pr_left  = len;
    pr_pad   = pad;
    pr_pos   = '0;
    pr_phase = (len == 0 && !pad) ? PH_CHDR : PH_SKIP;
  endtask

  // Advances the predicted parser by one request and queues any result.
  task automatic parse_request(logic eof, logic [7:0] b);
    logic [31:0]        p;
    logic [1:0]         q;
    logic signed [16:0] s;
    p = pr_pos;
    if (eof) begin
      case (pr_phase)
        PH_HDR:           report_error(ERR_NOT_WAVE);
        PH_CHDR, PH_SKIP: report_error(ERR_MISSING);
        PH_FMT:           report_error(ERR_BAD_FMT);
        PH_DATA:          report_error(ERR_SHORT_DATA);
        default: ;
      endcase
      clear_parser();
    end else begin
      case (pr_phase)
        PH_HDR: begin
          // The tag register takes the RIFF and WAVE words, not the size.
          if (p < 4 || p >= 8) pr_tag = {pr_tag[23:0], b};
          if ((p == 3 && pr_tag != TAG_RIFF) || (p == 11 && pr_tag != TAG_WAVE)) begin
            report_error(ERR_NOT_WAVE);
          end else begin
            pr_pos = p + 1;
            if (pr_pos >= 12) begin
              pr_phase = PH_CHDR;
              pr_pos   = '0;
            end
          end
        end
        PH_CHDR: begin
          if (p < 4) begin
            pr_tag = {pr_tag[23:0], b};
            if (p == 0) pr_left = '0;
          end else begin
            pr_left[8*(p-4) +: 8] = b;
          end
          pr_pos = p + 1;
          if (pr_pos == 8) begin
            pr_pos = '0;
            if (pr_tag == TAG_FMT) begin
              if (pr_left < FMT_BODY) begin
                report_error(ERR_BAD_FMT);
              end else begin
                pr_phase  = PH_FMT;
                pr_word_a = '0;
                pr_word_b = '0;
                pr_chans  = '0;
                pr_rate   = '0;
              end
            end else if (pr_tag == TAG_DATA) begin
              if (!pr_have_fmt) begin
                report_error(ERR_MISSING);
              end else if (pr_left == 0) begin
                pr_phase = PH_DONE;
                add_result(KIND_DONE, '0, 1'b0, '0, '0, '0);
              end else begin
                pr_phase = PH_DATA;
              end
            end else begin
              start_skip(pr_left, pr_left[0]);
            end
          end
        end
        PH_FMT: begin
          // Format tag, channels, rate, then bits per sample at the end.
          if (p < 2) pr_word_a[8*p +: 8] = b;
          else if (p < 4) pr_chans[8*(p-2) +: 8] = b;
          else if (p < 8) pr_rate[8*(p-4) +: 8] = b;
          else if (p >= 14) pr_word_b[8*(p-14) +: 8] = b;
          pr_pos = p + 1;
          if (pr_pos == FMT_BODY) begin
            if (pr_word_a != PCM_CODE) begin
              report_error(ERR_NOT_PCM);
            end else if (pr_word_b != PCM_BITS) begin
              report_error(ERR_NOT_16BIT);
            end else begin
              pr_have_fmt = 1'b1;
              start_skip(pr_left - FMT_BODY, pr_left[0]);
              add_result(KIND_FORMAT, '0, 1'b0, pr_chans, pr_rate, '0);
            end
          end
        end
        PH_SKIP: begin
          if (pr_left > 0) pr_left = pr_left - 1;
          else pr_pad = 1'b0;
          if (pr_left == 0 && !pr_pad) begin
            pr_phase = PH_CHDR;
            pr_pos   = '0;
          end
        end
        PH_DATA: begin
          q       = p[1:0];
          pr_left = pr_left - 1;
          pr_pos  = {30'd0, q + 2'd1};
          case (q)
            2'd0:    pr_word_a = {8'h00, b};
            2'd1:    pr_word_a[15:8] = b;
            2'd2:    pr_word_b = {8'h00, b};
            default: pr_word_b[15:8] = b;
          endcase
          if (q == 2'd3) begin
            s = $signed(pr_word_a) + $signed(pr_word_b);
            if (pr_left == 0) pr_phase = PH_DONE;
            add_result(KIND_SAMPLE, s, pr_left < 4, '0, '0, '0);
          end else if (pr_left == 0) begin
            // Trailing bytes that do not make a full pair close the chunk.
            pr_phase = PH_DONE;
            add_result(KIND_DONE, '0, 1'b0, '0, '0, '0);
          end
        end
        default: ;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // File building
  // ---------------------------------------------------------------------------

  task automatic app_byte(logic [7:0] b);
    file_q.push_back(b);
  endtask

  task automatic app_random(int n);
    repeat (n) app_byte(8'($urandom));
  endtask

  task automatic app_tag(logic [31:0] t);
    for (int i = 3; i >= 0; i--) app_byte(t[8*i +: 8]);
  endtask

  task automatic app_le16(logic [15:0] v);
    app_byte(v[7:0]);
    app_byte(v[15:8]);
  endtask

  task automatic app_le32(logic [31:0] v);
    for (int i = 0; i < 4; i++) app_byte(v[8*i +: 8]);
  endtask

  task automatic app_chunk_hdr(logic [31:0] tag, logic [31:0] len);
    app_tag(tag);
    app_le32(len);
  endtask

  task automatic app_header();
    app_tag(TAG_RIFF);
    app_le32($urandom);
    app_tag(TAG_WAVE);
  endtask

  task automatic app_fmt(logic [31:0] len, logic [15:0] code, logic [15:0] ch,
                         logic [31:0] rate, logic [15:0] bits);
    app_chunk_hdr(TAG_FMT, len);
    if (len < FMT_BODY) begin
      app_random(len);
    end else begin
      app_le16(code);
      app_le16(ch);
      app_le32(rate);
      app_random(6);
      app_le16(bits);
      app_random(len - FMT_BODY);
      if (len[0]) app_random(1);
    end
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic app_samples(int n);
    logic [15:0] s;
    for (int i = 0; i < n; i++) begin
      if (i % 2 == 0) s = pick_sample();
      app_byte((i % 2) ? s[15:8] : s[7:0]);
    end
  endtask

  // Chunk with a random tag; now and then a huge length that runs past the file.
  task automatic app_unknown();
    logic [31:0] tag;
    logic [31:0] len;
    tag = $urandom;
    if (tag == TAG_FMT || tag == TAG_DATA) tag = 32'h4A55_4E4B;
    len = ($urandom_range(0, 29) == 0) ? $urandom : $urandom_range(0, 5);
    app_chunk_hdr(tag, len);
    if (len > 6) begin
      app_random($urandom_range(0, 4));
    end else begin
      app_random(len);
      if (len[0]) app_random(1);
    end
  endtask

  task automatic app_random_fmt();
    logic [31:0] len;
    logic [15:0] code;
    logic [15:0] bits;
    len  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : 16 + $urandom_range(0, 3);
    code = ($urandom_range(0, 14) == 0) ? 16'($urandom) : PCM_CODE;
    bits = ($urandom_range(0, 14) == 0) ? 16'($urandom) : PCM_BITS;
    app_fmt(len, code, 16'($urandom), $urandom, bits);
  endtask

  // Queues the first cut bytes of the file and an end-of-file marker.
  task automatic emit_file(int cut, bit drain);
    for (int i = 0; i < cut; i++) begin
      req_q.push_back('{eof: 1'b0, b: file_q[i], drain: drain && i == 0});
    end
    req_q.push_back('{eof: 1'b1, b: 8'($urandom), drain: drain && cut == 0});
    file_q.delete();
  endtask

  task automatic make_directed();
    // Empty file.
    emit_file(0, 1'b0);
    // Wrong RIFF tag; the bytes after it are absorbed.
    app_tag(32'h5249_4658);
    app_random(3);
    emit_file(file_q.size(), 1'b0);
    // Wrong WAVE tag.
    app_tag(TAG_RIFF);
    app_le32(32'd36);
    app_tag(32'h5741_5646);
    emit_file(file_q.size(), 1'b0);
    // End of file inside the header.
    app_tag(TAG_RIFF);
    app_byte(8'h00);
    emit_file(file_q.size(), 1'b0);
    // fmt chunk shorter than its fixed body.
    app_header();
    app_fmt(32'd14, PCM_CODE, 16'd2, 32'd44100, PCM_BITS);
    emit_file(file_q.size(), 1'b0);
    // Not PCM.
    app_header();
    app_fmt(32'd16, 16'd3, 16'd2, 32'd48000, PCM_BITS);
    emit_file(file_q.size(), 1'b0);
    // Not 16 bits per sample.
    app_header();
    app_fmt(32'd16, PCM_CODE, 16'd1, 32'd8000, 16'd8);
    emit_file(file_q.size(), 1'b0);
    // End of file inside the fmt body.
    app_header();
    app_fmt(32'd16, PCM_CODE, 16'd2, 32'd44100, PCM_BITS);
    emit_file(file_q.size() - 7, 1'b0);
    // Data chunk before any fmt chunk.
    app_header();
    app_chunk_hdr(TAG_DATA, 32'd4);
    app_random(4);
    emit_file(file_q.size(), 1'b0);
    // Odd unknown chunk with pad, long fmt, extreme samples, trailing bytes.
    app_header();
    app_chunk_hdr(32'h4C49_5354, 32'd3);
    app_random(4);
    app_fmt(32'd18, PCM_CODE, 16'hFFFF, 32'hFFFF_FFFF, PCM_BITS);
    app_chunk_hdr(TAG_DATA, 32'd10);
    app_le16(16'h7FFF);
    app_le16(16'h7FFF);
    app_le16(16'h8000);
    app_le16(16'h8000);
    app_random(5);
    emit_file(file_q.size(), 1'b0);
    // Empty data chunk, entered only once everything before has drained.
    app_header();
    app_fmt(32'd16, PCM_CODE, 16'd0, 32'd0, PCM_BITS);
    app_chunk_hdr(TAG_DATA, 32'd0);
    emit_file(file_q.size(), 1'b1);
    // Data chunk made of whole pairs, so the last sample marks the end.
    app_header();
    app_fmt(32'd17, PCM_CODE, 16'd2, 32'd96000, PCM_BITS);
    app_chunk_hdr(TAG_DATA, 32'd8);
    app_samples(8);
    emit_file(file_q.size(), 1'b0);
    // End of file inside the data chunk.
    app_header();
    app_fmt(32'd16, PCM_CODE, 16'd2, 32'd22050, PCM_BITS);
    app_chunk_hdr(TAG_DATA, 32'hFFFF_FFFF);
    app_samples(6);
    emit_file(file_q.size(), 1'b0);
    // End of file between chunks, then inside a skipped chunk.
    app_header();
    app_fmt(32'd16, PCM_CODE, 16'd2, 32'd44100, PCM_BITS);
    emit_file(file_q.size(), 1'b0);
    app_header();
    app_chunk_hdr(32'h4A55_4E4B, 32'h0000_0010);
    app_random(3);
    emit_file(file_q.size(), 1'b0);
    // A later fmt chunk is checked too.
    app_header();
    app_fmt(32'd16, PCM_CODE, 16'd2, 32'd44100, PCM_BITS);
    app_fmt(32'd16, PCM_CODE, 16'd2, 32'd44100, 16'd24);
    emit_file(file_q.size(), 1'b0);
  endtask

  // Mostly well-formed files with random content, some broken or cut short.
  task automatic make_random_file();
    int sel;
    int len;
    if ($urandom_range(0, 19) == 0) begin
      app_random($urandom_range(0, 20));
      emit_file(file_q.size(), 1'b0);
    end else begin
      app_tag(($urandom_range(0, 24) == 0) ? TAG_RIFF ^ (32'h1 << $urandom_range(0, 31))
                                           : TAG_RIFF);
      app_le32($urandom);
      app_tag(($urandom_range(0, 24) == 0) ? TAG_WAVE ^ (32'h1 << $urandom_range(0, 31))
                                           : TAG_WAVE);
      repeat ($urandom_range(0, 1)) app_unknown();
      if ($urandom_range(0, 19) != 0) app_random_fmt();
      if ($urandom_range(0, 3) == 0) app_unknown();
      if ($urandom_range(0, 19) == 0) app_random_fmt();
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        app_chunk_hdr(TAG_DATA, 32'd0);
      end else if (sel == 1) begin
        app_chunk_hdr(TAG_DATA, {1'b1, 31'($urandom)});
        app_samples($urandom_range(0, 20));
      end else begin
        len = $urandom_range(1, 40);
        app_chunk_hdr(TAG_DATA, len);
        app_samples(len);
      end
      if ($urandom_range(0, 3) == 0) app_random($urandom_range(1, 6));
      emit_file(($urandom_range(0, 6) == 0) ? $urandom_range(0, file_q.size()) : file_q.size(),
                $urandom_range(0, 9) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver, receiver and monitor
  // ---------------------------------------------------------------------------

  // Sender: holds a request until taken, then waits its drawn gap.
  always @(negedge clk) begin
    request_t nxt;
    if (!rst && (!in_valid || in_took)) begin
      if (send_wait > 0) begin
        send_wait = send_wait - 1;
        in_valid <= 1'b0;
      end else if (req_q.size() > 0 && !(req_q[0].drain && parse_results_q.size() > 0)) begin
        nxt = req_q.pop_front();
        in_valid  <= 1'b1;
        op        <= nxt.eof;
        data_byte <= nxt.b;
        send_wait = quiet_mode ? 0 : $urandom_range(0, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls each result for a drawn number of cycles, and from the
  // first sample on holds off for a long stretch now and then so the parser
  // backs up.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_took) begin
        rcv_wait = quiet_mode ? 0 : $urandom_range(0, 8);
        if (sample_took && samples_seen % 40 == 1) rcv_hold = HOLD_CYCLES;
      end
      if (rcv_hold > 0) begin
        rcv_hold = rcv_hold - 1;
        out_stall <= 1'b1;
      end else if (rcv_wait > 0) begin
        if (out_valid) rcv_wait = rcv_wait - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic signed [32:0] want, logic signed [32:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      in_took     <= 1'b0;
      out_took    <= 1'b0;
      sample_took <= 1'b0;
    end else begin
      cycle_count++;
      if (cycle_count % 256 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
      in_took     <= in_valid && !in_stall;
      out_took    <= out_valid && !out_stall;
      sample_took <= out_valid && !out_stall && kind == KIND_SAMPLE;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (in_valid && !in_stall) parse_request(op, data_byte);
      if (out_valid && !out_stall) begin
        if (kind == KIND_SAMPLE) samples_seen++;
        if (parse_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d sum %0d error %0d",
                   $time, kind, mono_sum, error_code);
          errors++;
        end else begin
          want = parse_results_q.pop_front();
          check_field("kind", want.kind, kind);
          check_field("mono_sum", $signed(want.mono_sum), mono_sum);
          check_field("end_of_data", want.end_of_data, end_of_data);
          check_field("channel_count", want.channel_count, channel_count);
          check_field("rate_hz", want.rate_hz, rate_hz);
          check_field("error_code", want.error_code, error_code);
        end
      end
    end
  end

  // Watchdog on cycles with no traffic on either side.
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("wav_pcm16_chunk_parser test failed");
    $finish;
  end

  initial begin
    clear_parser();
    make_directed();
    while (req_q.size() < TOTAL_ITEMS) make_random_file();

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    wait (req_q.size() == 0 && !in_valid);
    wait (parse_results_q.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && parse_results_q.size() == 0) begin
      $display("wav_pcm16_chunk_parser test passed");
    end else begin
      $display("wav_pcm16_chunk_parser test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/wavp_pkg.sv
hw/rtl/wavp_step.sv
hw/rtl/wav_pcm16_chunk_parser.sv
hw/rtl/wavp_checker.sv
dv/tb_top.sv
